### rtl/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg
// Types, constants and round functions shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package s256_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] INITIAL_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

endpackage

### rtl/s256_queue.sv
// ----------------------------------------------------------------------------
// s256_queue
// Short word queue parting the input front from the hashing back end.
// ----------------------------------------------------------------------------
module s256_queue #(
    parameter int DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  s256_pkg::in_word_t push_word,
    output logic               full,
    input  logic               pop,
    output s256_pkg::in_word_t pop_word,
    output logic               empty
);
    import s256_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    in_word_t          slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_word = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count over depth");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |=> !(count_reg == (AW+1)'(DEPTH)))
        else $error("queue went from empty to full");
    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow");
`endif
endmodule

### rtl/s256_core.sv
// ----------------------------------------------------------------------------
// s256_core
// Back end: block buffer, padding, one-round-per-cycle compression, digest out.
// ----------------------------------------------------------------------------
module s256_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                word_valid,
    input  s256_pkg::in_word_t  word_in,
    output logic                word_take,
    output logic                out_valid,
    input  logic                out_stall,
    output s256_pkg::out_word_t out_word
);
    import s256_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]   state_reg, state_next;
    logic [31:0]  buf_mem [16];   // block held as big-endian words
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [5:0]   round_reg;
    logic [3:0]   ld_reg;         // schedule word being loaded
    logic         finish_reg;     // block belongs to the finish sequence
    logic         second_reg;     // final length block still to run
    logic [5:0]   pad_reg;
    logic [2:0]   emit_reg;
    logic [31:0]  w_new, t1, t2;

    always_comb
    begin
        w_new = sig1(w_reg[14]) + w_reg[9] + sig0(w_reg[1]) + w_reg[0];
        t1 = v_reg[7] + big_sig1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ROUND_K[round_reg] + w_reg[0];
        t2 = big_sig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign word_take = (state_reg == ST_IDLE) && word_valid;
    assign out_valid = (state_reg == ST_EMIT);
    assign out_word  = '{digest_word: h_reg[emit_reg], word_index: emit_reg,
                         last_word: (emit_reg == 3'd7)};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (word_valid)
                begin
                    if (word_in.op == OP_FINISH)
                    begin
                        // 0x80 lands in the last byte: nothing left to pad here
                        if (fill_reg == 6'd63)
                        begin
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            state_next = ST_PAD;
                        end
                    end
                    else if (fill_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (pad_reg == 6'd63)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (ld_reg == 4'd15)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (second_reg)
                begin
                    state_next = ST_PAD;
                end
                else if (finish_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall && emit_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Block buffer: absorbed bytes, then padding written one byte a cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && word_valid)
        begin
            buf_mem[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <=
                (word_in.op == OP_FINISH) ? 8'h80 : word_in.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            if (!second_reg && pad_reg >= 6'd56)
            begin
                buf_mem[pad_reg[5:2]][{~pad_reg[1:0], 3'b000} +: 8] <=
                    bits_reg[{~pad_reg[2:0], 3'b000} +: 8];
            end
            else
            begin
                buf_mem[pad_reg[5:2]][{~pad_reg[1:0], 3'b000} +: 8] <= 8'h00;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            w_reg[ld_reg] <= buf_mem[ld_reg];
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (state_reg == ST_LOAD && ld_reg == 4'd0)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            bits_reg   <= '0;
            round_reg  <= '0;
            ld_reg     <= '0;
            finish_reg <= 1'b0;
            second_reg <= 1'b0;
            pad_reg    <= '0;
            emit_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INITIAL_H[255 - 32 * i -: 32];
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    ld_reg    <= '0;
                    round_reg <= '0;
                    if (word_valid)
                    begin
                        if (word_in.op == OP_FINISH)
                        begin
                            finish_reg <= 1'b1;
                            second_reg <= (fill_reg >= 6'd56);
                            pad_reg    <= fill_reg + 1'b1;
                        end
                        else
                        begin
                            fill_reg <= fill_reg + 1'b1;
                            bits_reg <= bits_reg + 64'd8;
                            finish_reg <= 1'b0;
                        end
                    end
                end
                ST_PAD:
                begin
                    pad_reg <= pad_reg + 1'b1;
                end
                ST_LOAD:
                begin
                    ld_reg <= ld_reg + 1'b1;
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 1'b1;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (second_reg)
                    begin
                        second_reg <= 1'b0;
                        pad_reg    <= '0;
                    end
                    ld_reg    <= '0;
                    round_reg <= '0;
                    emit_reg  <= '0;
                end
                ST_EMIT:
                begin
                    if (!out_stall)
                    begin
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg == 3'd7)
                        begin
                            finish_reg <= 1'b0;
                            fill_reg   <= '0;
                            bits_reg   <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= INITIAL_H[255 - 32 * i -: 32];
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(emit_reg))
        else $error("digest word moved while stalled");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        word_take |-> state_reg == ST_IDLE)
        else $error("word taken while busy");
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> state_reg == ST_ADD)
        else $error("compression did not end after 64 rounds");
`endif
endmodule

### rtl/sha256_stream_hasher.sv
// An absorb word is taken while the core is idle; when it completes a block the core then runs
// 16 schedule loads, 64 rounds and the chain add. A finish word takes the padding
// sweep plus one or two blocks, then 8 digest words one per unstalled cycle.
// Throughput is set by the single round unit: the core takes no byte while a block runs.
// Reset loads the initial chaining values and clears counts; no clearing pass.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-fed SHA-256: input queue in front of the padding and compression core.
// ----------------------------------------------------------------------------
module sha256_stream_hasher #(
    parameter int QDEPTH = s256_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  s256_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output s256_pkg::out_word_t out_data
);
    import s256_pkg::*;

    logic     q_full, q_empty, core_take;
    in_word_t q_word;

    assign in_stall = q_full;

    s256_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_word (in_data),
        .full      (q_full),
        .pop       (core_take),
        .pop_word  (q_word),
        .empty     (q_empty)
    );

    s256_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (!q_empty),
        .word_in    (q_word),
        .word_take  (core_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_data)
    );

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");
    a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid)) |-> out_data.word_index == 3'd0)
        else $error("digest did not start at word zero");
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
        else $error("last flag out of step");
`endif
endmodule
